// File: rtl/assert_macros.svh
// Assertion macros shared by the linked list manager RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define LLM_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("linked list manager: invariant violated");

// A same-cycle implication checked at every clock edge outside reset.
`define LLM_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("linked list manager: implication violated");

`endif

// File: rtl/llm_pkg.sv
// Types, constants and the microcode table of the linked list manager.
package llm_pkg;

  localparam int unsigned NODES_DEF      = 16;
  localparam int unsigned DATA_WIDTH_DEF = 32;

  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned OP_W       = 3;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned HELD_W     = 5;
  localparam int unsigned OUT_DATA_W = 40;
  localparam int unsigned UPC_W      = 5;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_REMOVE     = 3'd2,
    OP_CLEAR      = 3'd3,
    OP_READ       = 3'd4
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    ACT_NOP,
    ACT_ACCEPT,
    ACT_SCAN_INIT,
    ACT_SCAN_STEP,
    ACT_PUSH_WRITE,
    ACT_LINK_TAIL,
    ACT_WALK_INIT,
    ACT_WALK_STEP,
    ACT_UNLINK,
    ACT_CLEAR,
    ACT_EMIT_OK,
    ACT_EMIT_EMPTY,
    ACT_EMIT_MISS,
    ACT_EMIT_FULL,
    ACT_EMIT_ENTRY
  } action_e;

  typedef enum logic [3:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NO_INPUT,
    COND_OP_PUSH,
    COND_OP_REMOVE,
    COND_OP_READ,
    COND_OP_CLEAR,
    COND_FULL,
    COND_SLOT_TAKEN,
    COND_FRONT_OR_EMPTY,
    COND_EMPTY,
    COND_MATCH,
    COND_WALK_MORE
  } cond_e;

  typedef logic [UPC_W-1:0] upc_t;

  // One control word: what the datapath does, and where to go when the
  // condition holds (otherwise the next step).
  typedef struct packed {
    action_e act;
    cond_e   cond;
    upc_t    target;
  } ucode_t;

  localparam upc_t STEP_IDLE       = 5'd0;
  localparam upc_t STEP_IS_PUSH    = 5'd1;
  localparam upc_t STEP_IS_REMOVE  = 5'd2;
  localparam upc_t STEP_IS_READ    = 5'd3;
  localparam upc_t STEP_IS_CLEAR   = 5'd4;
  localparam upc_t STEP_EMIT_OK    = 5'd5;
  localparam upc_t STEP_PUSH       = 5'd6;
  localparam upc_t STEP_SCAN       = 5'd7;
  localparam upc_t STEP_PUSH_WR    = 5'd8;
  localparam upc_t STEP_LINK_TAIL  = 5'd9;
  localparam upc_t STEP_REMOVE     = 5'd10;
  localparam upc_t STEP_COMPARE    = 5'd11;
  localparam upc_t STEP_ADVANCE    = 5'd12;
  localparam upc_t STEP_EMIT_MISS  = 5'd13;
  localparam upc_t STEP_UNLINK     = 5'd14;
  localparam upc_t STEP_READ       = 5'd15;
  localparam upc_t STEP_READ_ENTRY = 5'd16;
  localparam upc_t STEP_READ_DONE  = 5'd17;
  localparam upc_t STEP_CLEAR      = 5'd18;
  localparam upc_t STEP_EMIT_EMPTY = 5'd19;
  localparam upc_t STEP_EMIT_FULL  = 5'd20;

  function automatic ucode_t ucode_rom(upc_t step);
    ucode_t w;
    unique case (step)
      STEP_IDLE:       w = '{ACT_ACCEPT,     COND_NO_INPUT,       STEP_IDLE};
      STEP_IS_PUSH:    w = '{ACT_NOP,        COND_OP_PUSH,        STEP_PUSH};
      STEP_IS_REMOVE:  w = '{ACT_NOP,        COND_OP_REMOVE,      STEP_REMOVE};
      STEP_IS_READ:    w = '{ACT_NOP,        COND_OP_READ,        STEP_READ};
      STEP_IS_CLEAR:   w = '{ACT_NOP,        COND_OP_CLEAR,       STEP_CLEAR};
      STEP_EMIT_OK:    w = '{ACT_EMIT_OK,    COND_ALWAYS,         STEP_IDLE};
      STEP_PUSH:       w = '{ACT_SCAN_INIT,  COND_FULL,           STEP_EMIT_FULL};
      STEP_SCAN:       w = '{ACT_SCAN_STEP,  COND_SLOT_TAKEN,     STEP_SCAN};
      STEP_PUSH_WR:    w = '{ACT_PUSH_WRITE, COND_FRONT_OR_EMPTY, STEP_EMIT_OK};
      STEP_LINK_TAIL:  w = '{ACT_LINK_TAIL,  COND_ALWAYS,         STEP_EMIT_OK};
      STEP_REMOVE:     w = '{ACT_WALK_INIT,  COND_EMPTY,          STEP_EMIT_EMPTY};
      STEP_COMPARE:    w = '{ACT_NOP,        COND_MATCH,          STEP_UNLINK};
      STEP_ADVANCE:    w = '{ACT_WALK_STEP,  COND_WALK_MORE,      STEP_COMPARE};
      STEP_EMIT_MISS:  w = '{ACT_EMIT_MISS,  COND_ALWAYS,         STEP_IDLE};
      STEP_UNLINK:     w = '{ACT_UNLINK,     COND_ALWAYS,         STEP_EMIT_OK};
      STEP_READ:       w = '{ACT_WALK_INIT,  COND_EMPTY,          STEP_EMIT_EMPTY};
      STEP_READ_ENTRY: w = '{ACT_EMIT_ENTRY, COND_WALK_MORE,      STEP_READ_ENTRY};
      STEP_READ_DONE:  w = '{ACT_NOP,        COND_ALWAYS,         STEP_IDLE};
      STEP_CLEAR:      w = '{ACT_CLEAR,      COND_ALWAYS,         STEP_EMIT_OK};
      STEP_EMIT_EMPTY: w = '{ACT_EMIT_EMPTY, COND_ALWAYS,         STEP_IDLE};
      STEP_EMIT_FULL:  w = '{ACT_EMIT_FULL,  COND_ALWAYS,         STEP_IDLE};
      default:         w = '{ACT_NOP,        COND_ALWAYS,         STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage

// File: rtl/linked_list_manager.sv
// Top level of the linked list manager: microcoded sequencer, node memories and output register.
//
// The block keeps an ordered list of signed values in a pool of NODES nodes.
// Each transfer on the slave stream is one command: tuser carries the
// operation (push front, push back, remove first match, clear, read all)
// and tdata the value. Every command answers with one or more transfers on
// the master stream; tlast marks the final one of a command. Read all gives
// one transfer per entry from head to tail (one if the list is empty), every other command gives one.
// The work is run by a microprogram: one control word per step, a step
// counter and conditional jumps, over two node memories (values and links)
// whose read port follows the walk pointer. Read all visits one node per
// cycle while the receiver does not stall; remove compares and then advances
// for each node. A new command is taken only in the idle step. Pushes scan
// for the lowest free node, and push back onto a non-empty list also links
// the old tail. The first result leaves from an output register. Reset
// empties the list at once; node memories need no clearing.
// When the receiver stalls, the output register holds its transfer and
// the sequencer waits on its next emitting step; no result is lost.
module linked_list_manager #(
  parameter int unsigned NODES      = llm_pkg::NODES_DEF,
  parameter int unsigned DATA_WIDTH = llm_pkg::DATA_WIDTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [31:0] value
  input  logic [llm_pkg::VALUE_W-1:0]       s_axis_tdata,
  // [2:0] operation
  input  logic [llm_pkg::OP_W-1:0]          s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [31:0] entry_value, [36:32] entries_held, [39:37] zero
  output logic [llm_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  // [1:0] status
  output logic [llm_pkg::STATUS_W-1:0]      m_axis_tuser,
  output logic                              m_axis_tlast
);

  localparam int unsigned AW = $clog2(NODES);
  localparam int unsigned CW = $clog2(NODES + 1);

  // Sequencer.
  llm_pkg::upc_t   upc_q, upc_d;
  llm_pkg::ucode_t uw;
  logic            cond_true;
  logic            is_emit;
  logic            stall;
  logic            in_fire;

  // Command and walk registers.
  logic [llm_pkg::OP_W-1:0] op_q, op_d;
  logic [DATA_WIDTH-1:0]    val_q, val_d;
  logic [AW-1:0]            cur_q, cur_d;
  logic [AW-1:0]            prev_q, prev_d;
  logic [CW-1:0]            idx_q, idx_d;

  // List state.
  logic [NODES-1:0] occ_q, occ_d;
  logic [AW-1:0]    head_q, head_d;
  logic [AW-1:0]    tail_q, tail_d;
  logic [CW-1:0]    count_q, count_d;

  // Node memories, read at the next walk pointer.
  logic [DATA_WIDTH-1:0] val_mem [NODES];
  logic [AW-1:0]         link_mem [NODES];
  logic [DATA_WIDTH-1:0] rd_val_q;
  logic [AW-1:0]         rd_link_q;
  logic                  val_we;
  logic                  link_we;
  logic [AW-1:0]         link_wa;
  logic [AW-1:0]         link_wd;

  // Output register.
  logic                         out_valid_q, out_valid_d;
  logic [llm_pkg::VALUE_W-1:0]  out_value_q, out_value_d;
  llm_pkg::status_e             out_status_q, out_status_d;
  logic                         out_last_q, out_last_d;
  logic [llm_pkg::HELD_W-1:0]   out_held_q, out_held_d;

  logic is_front;
  logic walk_more;

  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (upc_q == llm_pkg::STEP_IDLE);
  assign is_front      = (op_q == llm_pkg::OP_PUSH_FRONT);
  assign walk_more     = ((idx_q + CW'(1)) < count_q);

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_held_q, out_value_q};
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tlast  = out_last_q;

  // Control word decode and branch condition.
  always_comb begin
    uw = llm_pkg::ucode_rom(upc_q);
    case (uw.act) inside
      llm_pkg::ACT_EMIT_OK, llm_pkg::ACT_EMIT_EMPTY, llm_pkg::ACT_EMIT_MISS,
      llm_pkg::ACT_EMIT_FULL, llm_pkg::ACT_EMIT_ENTRY: is_emit = 1'b1;
      default:                                         is_emit = 1'b0;
    endcase
    stall = is_emit && out_valid_q && !m_axis_tready;
    unique case (uw.cond)
      llm_pkg::COND_NEVER:          cond_true = 1'b0;
      llm_pkg::COND_ALWAYS:         cond_true = 1'b1;
      llm_pkg::COND_NO_INPUT:       cond_true = !s_axis_tvalid;
      llm_pkg::COND_OP_PUSH:        cond_true = (op_q == llm_pkg::OP_PUSH_FRONT) ||
                                                (op_q == llm_pkg::OP_PUSH_BACK);
      llm_pkg::COND_OP_REMOVE:      cond_true = (op_q == llm_pkg::OP_REMOVE);
      llm_pkg::COND_OP_READ:        cond_true = (op_q == llm_pkg::OP_READ);
      llm_pkg::COND_OP_CLEAR:       cond_true = (op_q == llm_pkg::OP_CLEAR);
      llm_pkg::COND_FULL:           cond_true = (count_q == CW'(NODES));
      llm_pkg::COND_SLOT_TAKEN:     cond_true = occ_q[cur_q];
      llm_pkg::COND_FRONT_OR_EMPTY: cond_true = is_front || (count_q == '0);
      llm_pkg::COND_EMPTY:          cond_true = (count_q == '0);
      llm_pkg::COND_MATCH:          cond_true = (rd_val_q == val_q);
      llm_pkg::COND_WALK_MORE:      cond_true = walk_more;
      default:                      cond_true = 1'b0;
    endcase
  end

  // Datapath driven by the current control word.
  always_comb begin
    upc_d        = upc_q;
    op_d         = op_q;
    val_d        = val_q;
    cur_d        = cur_q;
    prev_d       = prev_q;
    idx_d        = idx_q;
    occ_d        = occ_q;
    head_d       = head_q;
    tail_d       = tail_q;
    count_d      = count_q;
    val_we       = 1'b0;
    link_we      = 1'b0;
    link_wa      = cur_q;
    link_wd      = '0;
    out_valid_d  = out_valid_q && !m_axis_tready;
    out_value_d  = out_value_q;
    out_status_d = out_status_q;
    out_last_d   = out_last_q;
    out_held_d   = out_held_q;

    if (!stall) begin
      upc_d = cond_true ? uw.target : upc_q + llm_pkg::upc_t'(1);
      if (is_emit) begin
        out_valid_d  = 1'b1;
        out_value_d  = '0;
        out_last_d   = 1'b1;
        out_held_d   = llm_pkg::HELD_W'(count_q);
        out_status_d = llm_pkg::ST_OK;
      end
      unique case (uw.act)
        llm_pkg::ACT_ACCEPT: begin
          if (in_fire) begin
            op_d  = s_axis_tuser;
            val_d = DATA_WIDTH'($signed(s_axis_tdata));
          end
        end
        llm_pkg::ACT_SCAN_INIT: cur_d = '0;
        llm_pkg::ACT_SCAN_STEP: begin
          if (occ_q[cur_q]) begin
            cur_d = cur_q + AW'(1);
          end
        end
        llm_pkg::ACT_PUSH_WRITE: begin
          // New node goes into the free slot the scan stopped on.
          val_we         = 1'b1;
          link_we        = 1'b1;
          link_wa        = cur_q;
          link_wd        = (is_front && count_q != '0) ? head_q : '0;
          occ_d[cur_q]   = 1'b1;
          count_d        = count_q + CW'(1);
          if (count_q == '0) begin
            head_d = cur_q;
            tail_d = cur_q;
          end else if (is_front) begin
            head_d = cur_q;
          end
        end
        llm_pkg::ACT_LINK_TAIL: begin
          link_we = 1'b1;
          link_wa = tail_q;
          link_wd = cur_q;
          tail_d  = cur_q;
        end
        llm_pkg::ACT_WALK_INIT: begin
          cur_d  = head_q;
          prev_d = head_q;
          idx_d  = '0;
        end
        llm_pkg::ACT_WALK_STEP: begin
          prev_d = cur_q;
          cur_d  = rd_link_q;
          idx_d  = idx_q + CW'(1);
        end
        llm_pkg::ACT_UNLINK: begin
          occ_d[cur_q] = 1'b0;
          count_d      = count_q - CW'(1);
          if (count_q == CW'(1)) begin
            head_d = '0;
            tail_d = '0;
          end else if (idx_q == '0) begin
            head_d = rd_link_q;
          end else begin
            link_we = 1'b1;
            link_wa = prev_q;
            link_wd = rd_link_q;
            if (cur_q == tail_q) begin
              tail_d = prev_q;
            end
          end
        end
        llm_pkg::ACT_CLEAR: begin
          occ_d   = '0;
          head_d  = '0;
          tail_d  = '0;
          count_d = '0;
        end
        llm_pkg::ACT_EMIT_OK:    out_status_d = llm_pkg::ST_OK;
        llm_pkg::ACT_EMIT_EMPTY: out_status_d = llm_pkg::ST_EMPTY;
        llm_pkg::ACT_EMIT_MISS:  out_status_d = llm_pkg::ST_NOT_FOUND;
        llm_pkg::ACT_EMIT_FULL:  out_status_d = llm_pkg::ST_FULL;
        llm_pkg::ACT_EMIT_ENTRY: begin
          out_value_d = llm_pkg::VALUE_W'(rd_val_q);
          out_last_d  = !walk_more;
          cur_d       = rd_link_q;
          idx_d       = idx_q + CW'(1);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q       <= llm_pkg::STEP_IDLE;
      occ_q       <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      upc_q       <= upc_d;
      occ_q       <= occ_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    val_q        <= val_d;
    cur_q        <= cur_d;
    prev_q       <= prev_d;
    idx_q        <= idx_d;
    out_value_q  <= out_value_d;
    out_status_q <= out_status_d;
    out_last_q   <= out_last_d;
    out_held_q   <= out_held_d;
  end

  // Value memory: written on push, read every cycle at the next walk pointer.
  always_ff @(posedge clk_i) begin
    if (val_we) begin
      val_mem[cur_q] <= val_q;
    end
    rd_val_q <= val_mem[cur_d];
  end

  // Link memory: at most one write per cycle (new node, old tail or predecessor).
  always_ff @(posedge clk_i) begin
    if (link_we) begin
      link_mem[link_wa] <= link_wd;
    end
    rd_link_q <= link_mem[cur_d];
  end

`include "assert_macros.svh"

  `LLM_ASSERT_ALWAYS(a_count_bound, count_q <= CW'(NODES))
  `LLM_ASSERT_ALWAYS(a_count_matches_map, $countones(occ_q) == int'(count_q))
  `LLM_ASSERT_IMPLIES(a_head_occupied, count_q != '0, occ_q[head_q])
  `LLM_ASSERT_IMPLIES(a_tail_occupied, count_q != '0, occ_q[tail_q])

endmodule

// File: tb/sv/llm_result_monitor.sv
// Result monitor for the linked list manager: predicts every command and compares the results.
module llm_result_monitor
  import llm_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cmd_valid_i,
  input  logic                  cmd_ready_i,
  input  logic [VALUE_W-1:0]    cmd_value_i,
  input  logic [OP_W-1:0]       cmd_op_i,
  input  logic                  res_valid_i,
  input  logic                  res_ready_i,
  input  logic [OUT_DATA_W-1:0] res_data_i,
  input  logic [STATUS_W-1:0]   res_status_i,
  input  logic                  res_last_i,
  output int                    fail_count_o,
  output int                    pending_o
);

  localparam int unsigned POOL_SIZE = NODES_DEF;

  typedef struct packed {
    logic [VALUE_W-1:0] entry_value;
    status_e            status;
    logic               last;
    logic [HELD_W-1:0]  entries_held;
  } list_result_t;

  // The list as the block should hold it, head first.
  logic [VALUE_W-1:0] list_contents[$];
  list_result_t       expected_results[$];

  int mismatch_count = 0;
  int pending_count  = 0;

  assign fail_count_o = mismatch_count;
  assign pending_o    = pending_count;

  task automatic report_mismatch(input string what, input logic [OUT_DATA_W-1:0] got,
                                 input logic [OUT_DATA_W-1:0] want);
    $display("mismatch at %0t: %s: got %0h, expected %0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  task automatic expect_result(input logic [VALUE_W-1:0] value, input status_e status,
                               input logic last);
    list_result_t r;
    r.entry_value  = value;
    r.status       = status;
    r.last         = last;
    r.entries_held = HELD_W'(list_contents.size());
    expected_results.insert(expected_results.size(), r);
  endtask

  // Apply one command to the list and queue the results it must produce.
  task automatic predict_command(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] value);
    int hit;
    hit = -1;
    case (op)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (list_contents.size() >= POOL_SIZE) begin
          expect_result('0, ST_FULL, 1'b1);
        end else begin
          if (op == OP_PUSH_FRONT) list_contents.insert(0, value);
          else list_contents.insert(list_contents.size(), value);
          expect_result('0, ST_OK, 1'b1);
        end
      end
      OP_REMOVE: begin
        if (list_contents.size() == 0) begin
          expect_result('0, ST_EMPTY, 1'b1);
        end else begin
          for (int i = 0; i < list_contents.size() && hit < 0; i++) begin
            if (list_contents[i] == value) hit = i;
          end
          if (hit < 0) begin
            expect_result('0, ST_NOT_FOUND, 1'b1);
          end else begin
            list_contents.delete(hit);
            expect_result('0, ST_OK, 1'b1);
          end
        end
      end
      OP_CLEAR: begin
        list_contents.delete();
        expect_result('0, ST_OK, 1'b1);
      end
      OP_READ: begin
        if (list_contents.size() == 0) begin
          expect_result('0, ST_EMPTY, 1'b1);
        end else begin
          for (int i = 0; i < list_contents.size(); i++) begin
            expect_result(list_contents[i], ST_OK, i == list_contents.size() - 1);
          end
        end
      end
      default: expect_result('0, ST_OK, 1'b1);
    endcase
  endtask

  task automatic check_result();
    list_result_t want;
    if (expected_results.size() == 0) begin
      report_mismatch("result with nothing expected", res_data_i, '0);
      return;
    end
    want = expected_results.pop_front();
    if (res_data_i[VALUE_W-1:0] !== want.entry_value)
      report_mismatch("entry_value", OUT_DATA_W'(res_data_i[VALUE_W-1:0]),
                      OUT_DATA_W'(want.entry_value));
    if (res_data_i[VALUE_W+HELD_W-1:VALUE_W] !== want.entries_held)
      report_mismatch("entries_held", OUT_DATA_W'(res_data_i[VALUE_W+HELD_W-1:VALUE_W]),
                      OUT_DATA_W'(want.entries_held));
    if (res_data_i[OUT_DATA_W-1:VALUE_W+HELD_W] !== '0)
      report_mismatch("tdata padding", OUT_DATA_W'(res_data_i[OUT_DATA_W-1:VALUE_W+HELD_W]),
                      '0);
    if (res_status_i !== want.status)
      report_mismatch("status", OUT_DATA_W'(res_status_i), OUT_DATA_W'(want.status));
    if (res_last_i !== want.last)
      report_mismatch("last", OUT_DATA_W'(res_last_i), OUT_DATA_W'(want.last));
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cmd_valid_i && cmd_ready_i) predict_command(cmd_op_i, cmd_value_i);
      if (res_valid_i && res_ready_i) check_result();
      pending_count = expected_results.size();
    end
  end

endmodule

// File: tb/sv/tb.sv
// Testbench top for the linked list manager: clock, reset, command stimulus and verdict.
module tb;
  import llm_pkg::*;

  localparam int unsigned POOL_SIZE    = NODES_DEF;
  localparam int          RANDOM_ITEMS = 195;
  localparam int          PHASE_ITEMS  = 49;
  // Longest command walks the whole pool; this covers it with margin.
  localparam int          DRAIN_CYCLES = 4 * NODES_DEF;
  localparam logic [OP_W-1:0] OP_CODE_MAX = '1;

  // Idling phases of the random part.
  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_e;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  // [31:0] value
  logic [VALUE_W-1:0]    s_axis_tdata  = '0;
  // [2:0] operation
  logic [OP_W-1:0]       s_axis_tuser  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // [31:0] entry_value, [36:32] entries_held, [39:37] zero
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  // [1:0] status
  logic [STATUS_W-1:0]   m_axis_tuser;
  logic                  m_axis_tlast;

  int failures;
  int pending_results;

  // Idle rates in percent, changed per phase by the stimulus.
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  // Values that should be in the list right now; only used to aim removes
  // at entries that exist and to know when the pool is full.
  logic [VALUE_W-1:0] held_values[$];
  int                 items_sent = 0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  linked_list_manager u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  llm_result_monitor u_result_monitor (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (s_axis_tvalid),
    .cmd_ready_i  (s_axis_tready),
    .cmd_value_i  (s_axis_tdata),
    .cmd_op_i     (s_axis_tuser),
    .res_valid_i  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .res_data_i   (m_axis_tdata),
    .res_status_i (m_axis_tuser),
    .res_last_i   (m_axis_tlast),
    .fail_count_o (failures),
    .pending_o    (pending_results)
  );

  // The receiver draws a fresh ready every cycle, so stalls land on every
  // result of a readout, not only on the first.
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Values lean on a small set so that duplicates and remove hits are common,
  // with the extremes of the signed range mixed in and fully random words for
  // bit coverage.
  function automatic logic [VALUE_W-1:0] pick_value();
    int roll;
    roll = $urandom_range(99);
    if (roll < 30) return VALUE_W'($urandom_range(7));
    if (roll < 35) return 32'h8000_0000;
    if (roll < 40) return 32'h7fff_ffff;
    if (roll < 43) return 32'hffff_ffff;
    return $urandom();
  endfunction

  // One command transfer. tvalid is only lowered when the sender takes a gap,
  // so back-to-back commands never lower and raise it in one time step.
  task automatic send_command(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] value);
    int hit;
    hit = -1;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
    case (op)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (held_values.size() < POOL_SIZE) held_values.insert(held_values.size(), value);
      end
      OP_REMOVE: begin
        for (int i = 0; i < held_values.size() && hit < 0; i++) begin
          if (held_values[i] == value) hit = i;
        end
        if (hit >= 0) held_values.delete(hit);
      end
      OP_CLEAR: held_values.delete();
      default: ;
    endcase
  endtask

  // Stop sending and wait until every expected result has been seen. The
  // extra edge lets the monitor register a command accepted at the last edge.
  task automatic pause_until_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_results != 0) @(posedge clk_i);
  endtask

  // A random command, with removes mostly aimed at values that are present.
  task automatic send_random_command();
    int roll;
    roll = $urandom_range(99);
    if (roll < 22) begin
      send_command(OP_PUSH_FRONT, pick_value());
    end else if (roll < 44) begin
      send_command(OP_PUSH_BACK, pick_value());
    end else if (roll < 64) begin
      if (held_values.size() > 0 && $urandom_range(99) < 70)
        send_command(OP_REMOVE, held_values[$urandom_range(held_values.size() - 1)]);
      else
        send_command(OP_REMOVE, pick_value());
    end else if (roll < 80) begin
      send_command(OP_READ, $urandom());
    end else if (roll < 86) begin
      send_command(OP_CLEAR, $urandom());
    end else if (roll < 91) begin
      send_command(OP_W'($urandom_range(int'(OP_CODE_MAX), int'(OP_READ) + 1)), $urandom());
    end else begin
      send_command(OP_PUSH_BACK, pick_value());
    end
  endtask

  task automatic set_idling(input idle_mode_e mode);
    case (mode)
      IDLE_SENDER:   begin send_idle_pct = 55; recv_stall_pct = 0;  end
      IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 55; end
      IDLE_BOTH:     begin send_idle_pct = 6;  recv_stall_pct = 6;  end
      default:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
    endcase
  endtask

  // Run limit, far above the slowest legal run.
  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int         random_start;
    int         episode;
    int         roll;
    idle_mode_e mode;
    idle_mode_e next_mode;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: commands on an empty list, unknown operation codes,
    // pushes of the signed extremes at both ends, removes that miss and that
    // hit the middle, the tail, the head and the only entry, and a duplicate
    // value where only the first match goes.
    send_command(OP_READ, '0);
    send_command(OP_REMOVE, 32'h0000_0005);
    send_command(OP_CLEAR, '0);
    for (int code = int'(OP_READ) + 1; code <= int'(OP_CODE_MAX); code++) begin
      send_command(OP_W'(code), $urandom());
    end
    send_command(OP_PUSH_BACK,  32'h7fff_ffff);
    send_command(OP_PUSH_FRONT, 32'h8000_0000);
    send_command(OP_PUSH_BACK,  32'h0000_0000);
    send_command(OP_PUSH_FRONT, 32'hffff_ffff);
    send_command(OP_READ, '0);
    send_command(OP_REMOVE, 32'h0000_3039);
    send_command(OP_REMOVE, 32'h8000_0000);
    send_command(OP_REMOVE, 32'h0000_0000);
    send_command(OP_REMOVE, 32'hffff_ffff);
    send_command(OP_READ, '0);
    send_command(OP_REMOVE, 32'h7fff_ffff);
    send_command(OP_READ, '0);
    send_command(OP_PUSH_BACK, 32'h0000_0005);
    send_command(OP_PUSH_FRONT, 32'h0000_0005);
    send_command(OP_PUSH_BACK, 32'h0000_0009);
    send_command(OP_REMOVE, 32'h0000_0005);
    send_command(OP_READ, '0);
    send_command(OP_CLEAR, '0);
    send_command(OP_READ, '0);

    // Hold off the sender until the block has answered everything.
    pause_until_drained();

    // Random part in episodes. The first always fills the pool so that pushes
    // into a full pool are certain; later ones fill, drain or mix.
    random_start = items_sent;
    mode         = IDLE_NONE;
    set_idling(mode);
    episode      = 0;
    while (items_sent - random_start < RANDOM_ITEMS) begin
      next_mode = idle_mode_e'(((items_sent - random_start) / PHASE_ITEMS) % 4);
      if (next_mode != mode) begin
        pause_until_drained();
        mode = next_mode;
        set_idling(mode);
      end
      roll = (episode == 0) ? 0 : $urandom_range(99);
      if (roll < 20) begin
        while (held_values.size() < POOL_SIZE) begin
          send_command($urandom_range(1) ? OP_PUSH_FRONT : OP_PUSH_BACK, pick_value());
        end
        send_command(OP_PUSH_BACK, pick_value());
        send_command(OP_PUSH_FRONT, pick_value());
        send_command(OP_READ, $urandom());
      end else if (roll < 35) begin
        while (held_values.size() > 0) begin
          send_command(OP_REMOVE, held_values[$urandom_range(held_values.size() - 1)]);
        end
        send_command(OP_REMOVE, pick_value());
        send_command(OP_READ, $urandom());
      end else begin
        repeat (10) send_random_command();
      end
      episode++;
    end

    // Wind down: wait for the last results, then a little longer so that any
    // stray transfer is caught.
    pause_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (failures == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
